[hw/rtl/hrmp_pkg.sv]
`default_nettype none

package hrmp_pkg;

   // Ring and packet sizing.
   localparam int RR_SLOTS     = 8;
   localparam int PACKET_BYTES = 20;
   localparam int PTR_W        = $clog2(RR_SLOTS);
   localparam int LEN_W        = $clog2(PACKET_BYTES + 1) < 3 ? 3 : $clog2(PACKET_BYTES + 1);
   localparam int ROOM_W       = $clog2(PACKET_BYTES / 2 + 1);
   localparam int RR_W         = 16;

   // Action codes.
   localparam logic [2:0] ACT_SET_RATE     = 3'd0;
   localparam logic [2:0] ACT_SET_ENERGY   = 3'd1;
   localparam logic [2:0] ACT_ADD_RR       = 3'd2;
   localparam logic [2:0] ACT_RESET_ENERGY = 3'd3;
   localparam logic [2:0] ACT_SET_CONTACT  = 3'd4;
   localparam logic [2:0] ACT_SEND         = 3'd5;

   // Flag bit positions.
   localparam int FLAG_WIDE_BIT   = 0;
   localparam int FLAG_ENERGY_BIT = 3;
   localparam int FLAG_RR_BIT     = 4;
   localparam logic [7:0] FLAG_CONTACT_MASK = 8'h06;

   // Narrow rate limit.
   localparam logic [15:0] RATE_NARROW_MAX = 16'h00FF;

   // Ring pointer advance with wrap.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p >= PTR_W'(RR_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/hrmp_rr_ram.sv]
`default_nettype none

// Simple dual-port RAM with a registered read port.
module hrmp_rr_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered on rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/heart_rate_measurement_packer.sv]
// A send pushes its header bytes, then walks the RR ring, reading each slot from memory and then
// checking it, and flushes the held byte as the final word; busy stays high until it is done.
// Other actions are taken back to back. One byte word is strobed per cycle at most.
// Reset (synchronous, active high) clears notify, rate, energy, flags, pointer and valid bits.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`default_nettype none

module heart_rate_measurement_packer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_value,
   output      logic        rsp_strobe,
   output      logic [7:0]  rsp_packet_byte,
   output      logic        rsp_last_byte,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_RD,
      ST_CHK,
      ST_HI,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic                           notify_ff, notify_in;
   logic [15:0]                    rate_ff, rate_in;
   logic [15:0]                    energy_ff, energy_in;
   logic [7:0]                     flags_ff, flags_in;
   logic [hrmp_pkg::PTR_W-1:0]     wp_ff, wp_in;
   logic                           valid_ff [hrmp_pkg::RR_SLOTS];
   logic                           valid_in [hrmp_pkg::RR_SLOTS];

   // Send context.
   logic [7:0]                     hdr_flags_ff, hdr_flags_in;
   logic                           hdr_wide_ff, hdr_wide_in;
   logic [2:0]                     hdr_last_ff, hdr_last_in;
   logic [2:0]                     hidx_ff, hidx_in;
   logic                           walk_ff, walk_in;
   logic [hrmp_pkg::ROOM_W-1:0]    room_ff, room_in;
   logic [hrmp_pkg::PTR_W-1:0]     ptr_ff, ptr_in;
   logic [7:0]                     hi_ff, hi_in;
   logic                           more_ff, more_in;

   // Pending byte and output registers.
   logic [7:0]                     pend_ff, pend_in;
   logic                           pend_vld_ff, pend_vld_in;
   logic                           strobe_ff, strobe_in;
   logic [7:0]                     obyte_ff, obyte_in;
   logic                           olast_ff, olast_in;

   // Memory port signals.
   logic                           ram_wr_en;
   logic [hrmp_pkg::PTR_W-1:0]     ram_wr_addr;
   logic                           ram_rd_en;
   logic [hrmp_pkg::PTR_W-1:0]     ram_rd_addr;
   logic [hrmp_pkg::RR_W-1:0]      ram_rd_data;

   // Working signals.
   logic                           accept;
   logic                           push;
   logic [7:0]                     push_byte;
   logic [7:0]                     hdr_byte;
   logic                           wide;
   logic                           energy_on;
   logic [2:0]                     hdr_len;
   logic [hrmp_pkg::LEN_W-1:0]     len_ext;
   logic [hrmp_pkg::LEN_W-1:0]     room_diff;
   logic [hrmp_pkg::ROOM_W-1:0]    room_start;
   logic [15:0]                    slot_val;
   logic                           slot_hit;
   logic                           at_end;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Header layout for the send that is about to start.
   assign wide      = (rate_ff > hrmp_pkg::RATE_NARROW_MAX);
   assign energy_on = flags_ff[hrmp_pkg::FLAG_ENERGY_BIT];
   assign hdr_len   = 3'd2 + {2'b00, wide} + {1'b0, energy_on, 1'b0};
   assign len_ext   = hrmp_pkg::LEN_W'(hdr_len);
   assign room_diff = hrmp_pkg::LEN_W'(hrmp_pkg::PACKET_BYTES) - len_ext;
   assign room_start = (len_ext < hrmp_pkg::LEN_W'(hrmp_pkg::PACKET_BYTES)) ?
                       hrmp_pkg::ROOM_W'(room_diff >> 1) : '0;

   // Header byte selection by position.
   always_comb begin
      hdr_byte = 8'h00;
      unique case (hidx_ff)
         3'd0:    hdr_byte = hdr_flags_ff;
         3'd1:    hdr_byte = rate_ff[7:0];
         3'd2:    hdr_byte = hdr_wide_ff ? rate_ff[15:8] : energy_ff[7:0];
         3'd3:    hdr_byte = hdr_wide_ff ? energy_ff[7:0] : energy_ff[15:8];
         3'd4:    hdr_byte = energy_ff[15:8];
         default: hdr_byte = 8'h00;
      endcase
   end

   // An empty ring slot reads as zero.
   assign slot_val = valid_ff[ptr_ff] ? ram_rd_data : 16'h0000;
   assign slot_hit = (slot_val != 16'h0000);
   assign at_end   = (ptr_ff == wp_ff);

   // Memory access: adds write when idle, the walk reads one slot ahead.
   assign ram_wr_en   = accept && (req_action == hrmp_pkg::ACT_ADD_RR);
   assign ram_wr_addr = hrmp_pkg::next_slot(wp_ff);
   assign ram_rd_en   = (state_ff == ST_RD);
   assign ram_rd_addr = hrmp_pkg::next_slot(ptr_ff);

   hrmp_rr_ram #(
      .DEPTH (hrmp_pkg::RR_SLOTS),
      .WIDTH (hrmp_pkg::RR_W)
   ) u_rr_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      notify_in    = notify_ff;
      rate_in      = rate_ff;
      energy_in    = energy_ff;
      flags_in     = flags_ff;
      wp_in        = wp_ff;
      valid_in     = valid_ff;
      hdr_flags_in = hdr_flags_ff;
      hdr_wide_in  = hdr_wide_ff;
      hdr_last_in  = hdr_last_ff;
      hidx_in      = hidx_ff;
      walk_in      = walk_ff;
      room_in      = room_ff;
      ptr_in       = ptr_ff;
      hi_in        = hi_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      strobe_in    = 1'b0;
      obyte_in     = obyte_ff;
      olast_in     = 1'b0;
      push         = 1'b0;
      push_byte    = 8'h00;

      if (csr_valid && csr_ready) begin
         notify_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  hrmp_pkg::ACT_SET_RATE: begin
                     rate_in = req_value;
                  end
                  hrmp_pkg::ACT_SET_ENERGY: begin
                     energy_in = req_value;
                     flags_in[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b1;
                  end
                  hrmp_pkg::ACT_ADD_RR: begin
                     flags_in[hrmp_pkg::FLAG_RR_BIT] = 1'b1;
                     wp_in = ram_wr_addr;
                     valid_in[ram_wr_addr] = 1'b1;
                  end
                  hrmp_pkg::ACT_RESET_ENERGY: begin
                     energy_in = 16'h0000;
                     flags_in[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b1;
                  end
                  hrmp_pkg::ACT_SET_CONTACT: begin
                     flags_in = (flags_ff & ~hrmp_pkg::FLAG_CONTACT_MASK) |
                                {5'b00000, req_value[1:0], 1'b0};
                  end
                  hrmp_pkg::ACT_SEND: begin
                     if (notify_ff) begin
                        hdr_flags_in = flags_ff;
                        hdr_flags_in[hrmp_pkg::FLAG_WIDE_BIT] = wide;
                        hdr_wide_in  = wide;
                        hdr_last_in  = hdr_len - 3'd1;
                        hidx_in      = 3'd0;
                        walk_in      = flags_ff[hrmp_pkg::FLAG_RR_BIT] &&
                                       (room_start != '0);
                        room_in      = room_start;
                        ptr_in       = wp_ff;
                        flags_in[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b0;
                        state_in     = ST_HDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One header byte per cycle.
         ST_HDR: begin
            push      = 1'b1;
            push_byte = hdr_byte;
            hidx_in   = hidx_ff + 3'd1;
            if (hidx_ff == hdr_last_ff) begin
               state_in = walk_ff ? ST_RD : ST_DONE;
            end
         end

         // Read the next ring slot.
         ST_RD: begin
            ptr_in   = ram_rd_addr;
            state_in = ST_CHK;
         end

         // Clear the slot and send it if nonzero; stop at the newest slot or when full.
         ST_CHK: begin
            valid_in[ptr_ff] = 1'b0;
            if (at_end) begin
               flags_in[hrmp_pkg::FLAG_RR_BIT] = 1'b0;
            end
            if (slot_hit) begin
               push      = 1'b1;
               push_byte = slot_val[7:0];
               hi_in     = slot_val[15:8];
               room_in   = room_ff - hrmp_pkg::ROOM_W'(1);
               more_in   = !at_end && (room_ff != hrmp_pkg::ROOM_W'(1));
               state_in  = ST_HI;
            end else begin
               state_in  = at_end ? ST_DONE : ST_RD;
            end
         end

         ST_HI: begin
            push      = 1'b1;
            push_byte = hi_ff;
            state_in  = more_ff ? ST_RD : ST_DONE;
         end

         // Flush the held byte as the final word.
         ST_DONE: begin
            strobe_in   = 1'b1;
            obyte_in    = pend_ff;
            olast_in    = 1'b1;
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Each new byte releases the one held before it.
      if (push) begin
         if (pend_vld_ff) begin
            strobe_in = 1'b1;
            obyte_in  = pend_ff;
            olast_in  = 1'b0;
         end
         pend_in     = push_byte;
         pend_vld_in = 1'b1;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         notify_ff   <= 1'b0;
         rate_ff     <= 16'h0000;
         energy_ff   <= 16'h0000;
         flags_ff    <= 8'h00;
         wp_ff       <= '0;
         for (int i = 0; i < hrmp_pkg::RR_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         pend_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         olast_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         notify_ff   <= notify_in;
         rate_ff     <= rate_in;
         energy_ff   <= energy_in;
         flags_ff    <= flags_in;
         wp_ff       <= wp_in;
         valid_ff    <= valid_in;
         pend_vld_ff <= pend_vld_in;
         strobe_ff   <= strobe_in;
         olast_ff    <= olast_in;
      end
      hdr_flags_ff <= hdr_flags_in;
      hdr_wide_ff  <= hdr_wide_in;
      hdr_last_ff  <= hdr_last_in;
      hidx_ff      <= hidx_in;
      walk_ff      <= walk_in;
      room_ff      <= room_in;
      ptr_ff       <= ptr_in;
      hi_ff        <= hi_in;
      more_ff      <= more_in;
      pend_ff      <= pend_in;
      obyte_ff     <= obyte_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_packet_byte = obyte_ff;
   assign rsp_last_byte   = olast_ff;

   // A packet's final word is never followed at once by another word.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_byte |=> !rsp_strobe)
      else $error("word strobed right after a final word");

   // The flush always has a held byte to send.
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> pend_vld_ff)
      else $error("packet end with no held byte");

   // An enabled send starts a busy sequence.
   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == hrmp_pkg::ACT_SEND && notify_ff |=> busy)
      else $error("send accepted without starting a packet");

   // The ring is only written while no walk is in progress.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_IDLE)
      else $error("ring write during a send");

endmodule

`default_nettype wire

[verif/hrmp_packet_checker.sv]
`timescale 1ns / 1ps

module hrmp_packet_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_value,
   input  wire logic        rsp_strobe,
   input  wire logic [7:0]  rsp_packet_byte,
   input  wire logic        rsp_last_byte,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_wdata,
   output int               fail_count,
   output int               pending_words
);

   // One packet word as the block strobes it out.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packet_word_type;

   packet_word_type expected_words[$];

   // Shadow copy of the measurement state and the notify register.
   logic [15:0]                rate_q;
   logic [15:0]                energy_q;
   logic [7:0]                 flags_q;
   logic [15:0]                ring_q [hrmp_pkg::RR_SLOTS];
   logic [hrmp_pkg::PTR_W-1:0] wptr_q;
   logic                       notify_q;

   initial begin
      fail_count    = 0;
      pending_words = 0;
   end

   // Ring position after p, wrapping at the last slot.
   function automatic logic [hrmp_pkg::PTR_W-1:0] ring_advance(
      input logic [hrmp_pkg::PTR_W-1:0] p);
      return (int'(p) == hrmp_pkg::RR_SLOTS - 1) ? '0 : p + 1'b1;
   endfunction

   always @(posedge clock) begin : predict_and_compare
      logic [7:0]                 pkt [hrmp_pkg::PACKET_BYTES + 8];
      int                         n;
      int                         room_end;
      logic [hrmp_pkg::PTR_W-1:0] p;
      logic                       walk_done;
      packet_word_type            w;

      if (reset) begin
         rate_q   = '0;
         energy_q = '0;
         flags_q  = '0;
         wptr_q   = '0;
         notify_q = 1'b0;
         for (int i = 0; i < hrmp_pkg::RR_SLOTS; i++) begin
            ring_q[i] = '0;
         end
         expected_words.delete();
      end else begin
         // Compare a strobed word with the oldest expected one.
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $error("packet_byte: unexpected word, actual %02h last_byte %0b",
                      rsp_packet_byte, rsp_last_byte);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_packet_byte !== w.data) begin
                  $error("packet_byte mismatch: expected %02h actual %02h",
                         w.data, rsp_packet_byte);
                  fail_count++;
               end
               if (rsp_last_byte !== w.last) begin
                  $error("last_byte mismatch: expected %0b actual %0b",
                         w.last, rsp_last_byte);
                  fail_count++;
               end
            end
         end

         // Update the shadow state for an accepted command word.
         if (start && !busy) begin
            case (req_action)
               hrmp_pkg::ACT_SET_RATE: begin
                  rate_q = req_value;
               end
               hrmp_pkg::ACT_SET_ENERGY: begin
                  energy_q = req_value;
                  flags_q[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b1;
               end
               hrmp_pkg::ACT_ADD_RR: begin
                  flags_q[hrmp_pkg::FLAG_RR_BIT] = 1'b1;
                  wptr_q = ring_advance(wptr_q);
                  ring_q[wptr_q] = req_value;
               end
               hrmp_pkg::ACT_RESET_ENERGY: begin
                  energy_q = '0;
                  flags_q[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b1;
               end
               hrmp_pkg::ACT_SET_CONTACT: begin
                  flags_q = (flags_q & ~hrmp_pkg::FLAG_CONTACT_MASK) |
                            {5'b0, req_value[1:0], 1'b0};
               end
               hrmp_pkg::ACT_SEND: begin
                  if (notify_q) begin
                     // Header: flags with the wide rate decision, the rate, then the energy if flagged.
                     pkt[0] = flags_q;
                     pkt[0][hrmp_pkg::FLAG_WIDE_BIT] = (rate_q > hrmp_pkg::RATE_NARROW_MAX);
                     pkt[1] = rate_q[7:0];
                     n = 2;
                     if (rate_q > hrmp_pkg::RATE_NARROW_MAX) begin
                        pkt[2] = rate_q[15:8];
                        n = 3;
                     end
                     if (flags_q[hrmp_pkg::FLAG_ENERGY_BIT]) begin
                        flags_q[hrmp_pkg::FLAG_ENERGY_BIT] = 1'b0;
                        pkt[n]     = energy_q[7:0];
                        pkt[n + 1] = energy_q[15:8];
                        n += 2;
                     end
                     // Walk the ring oldest first within the even room left.
                     if (flags_q[hrmp_pkg::FLAG_RR_BIT]) begin
                        room_end = n;
                        if (n < hrmp_pkg::PACKET_BYTES) begin
                           room_end = n + ((hrmp_pkg::PACKET_BYTES - n) & ~1);
                        end
                        p = wptr_q;
                        walk_done = 1'b0;
                        while (n < room_end && !walk_done) begin
                           p = ring_advance(p);
                           if (ring_q[p] != '0) begin
                              pkt[n]     = ring_q[p][7:0];
                              pkt[n + 1] = ring_q[p][15:8];
                              n += 2;
                              ring_q[p] = '0;
                           end
                           if (p == wptr_q) begin
                              flags_q[hrmp_pkg::FLAG_RR_BIT] = 1'b0;
                              walk_done = 1'b1;
                           end
                        end
                     end
                     for (int i = 0; i < n; i++) begin
                        w.data = pkt[i];
                        w.last = (i == n - 1);
                        expected_words.push_back(w);
                     end
                  end
               end
               default: begin
                  // Spare action codes leave everything as it is.
               end
            endcase
         end

         // A register write takes effect after this edge.
         if (csr_valid && csr_ready) begin
            notify_q = csr_wdata;
         end
      end
      pending_words = expected_words.size();
   end

endmodule

[verif/heart_rate_measurement_packer_tb.sv]
`timescale 1ns / 1ps

module heart_rate_measurement_packer_tb;

   // Action codes the block does not use.
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        start      = 1'b0;
   logic [2:0]  req_action = '0;
   logic [15:0] req_value  = '0;
   logic        csr_valid  = 1'b0;
   logic        csr_wdata  = 1'b0;

   wire         busy;
   wire         rsp_strobe;
   wire [7:0]   rsp_packet_byte;
   wire         rsp_last_byte;
   wire         csr_ready;

   int          fail_count;
   int          pending_words;
   int          cycle_count = 0;

   heart_rate_measurement_packer DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   hrmp_packet_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_words   (pending_words)
   );

   always #2 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Field values biased toward the rate and byte boundaries.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return hrmp_pkg::RATE_NARROW_MAX;
         3:       return hrmp_pkg::RATE_NARROW_MAX + 16'd1;
         4, 5:    return 16'($urandom_range(1, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return hrmp_pkg::ACT_ADD_RR;
      if (r < 50) return hrmp_pkg::ACT_SEND;
      if (r < 62) return hrmp_pkg::ACT_SET_RATE;
      if (r < 72) return hrmp_pkg::ACT_SET_ENERGY;
      if (r < 78) return hrmp_pkg::ACT_RESET_ENERGY;
      if (r < 90) return hrmp_pkg::ACT_SET_CONTACT;
      return (r < 95) ? ACT_SPARE_A : ACT_SPARE_B;
   endfunction

   // Hold start low while the fields carry noise; n sets how long.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start      <= 1'b0;
         req_action <= 3'($urandom);
         req_value  <= 16'($urandom);
      end
   endtask

   // Present one command word and wait until the block takes it.
   task automatic issue_word(input logic [2:0] action, input logic [15:0] value);
      @(negedge clock);
      start      <= 1'b1;
      req_action <= action;
      req_value  <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending and wait until every expected word has come out.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the notify register while the block is idle.
   task automatic write_notify(input logic enable);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= enable;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random command words; spare action codes do not count.
   task automatic random_run(input int count, input bit with_gaps);
      int          taken;
      logic [2:0]  action;
      taken = 0;
      while (taken < count) begin
         action = pick_action();
         if (with_gaps) idle_cycles(pick_gap());
         issue_word(action, pick_value());
         if (action <= hrmp_pkg::ACT_SEND) taken++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A send with notifications still off after reset emits nothing.
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      write_notify(1'b1);
      issue_word(hrmp_pkg::ACT_SEND, 16'hFFFF);

      // Narrow rate at its top, then the wide form with energy.
      issue_word(hrmp_pkg::ACT_SET_RATE, hrmp_pkg::RATE_NARROW_MAX);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      issue_word(hrmp_pkg::ACT_SET_RATE, hrmp_pkg::RATE_NARROW_MAX + 16'd1);
      issue_word(hrmp_pkg::ACT_SET_ENERGY, 16'hFFFF);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      issue_word(hrmp_pkg::ACT_SET_RATE, 16'hFFFF);
      issue_word(hrmp_pkg::ACT_RESET_ENERGY, 16'hFFFF);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);

      // Contact bits come from the low two bits of the value only.
      issue_word(hrmp_pkg::ACT_SET_CONTACT, 16'hFFFF);
      issue_word(hrmp_pkg::ACT_SET_CONTACT, 16'hFFFC);
      issue_word(hrmp_pkg::ACT_SET_CONTACT, 16'h0002);

      // A zero interval is never sent; a ring of zeros still clears the RR flag.
      issue_word(hrmp_pkg::ACT_ADD_RR, 16'hFFFF);
      issue_word(hrmp_pkg::ACT_ADD_RR, 16'h0000);
      issue_word(hrmp_pkg::ACT_ADD_RR, 16'h0001);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      issue_word(hrmp_pkg::ACT_ADD_RR, 16'h0000);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);

      // A full ring behind the widest header overflows the room of one packet.
      issue_word(hrmp_pkg::ACT_SET_ENERGY, 16'h1234);
      repeat (hrmp_pkg::RR_SLOTS)
         issue_word(hrmp_pkg::ACT_ADD_RR, 16'($urandom_range(1, 65535)));
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      issue_word(hrmp_pkg::ACT_SEND, 16'h0000);
      issue_word(ACT_SPARE_A, 16'hFFFF);
      issue_word(ACT_SPARE_B, 16'h0000);

      // Random traffic across several register settings.
      random_run(50, 1'b1);
      write_notify(1'b0);
      random_run(15, 1'b1);
      write_notify(1'b1);
      random_run(25, 1'b0);
      settle();
      random_run(45, 1'b1);

      settle();
      if (fail_count == 0 && pending_words == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/hrmp_pkg.sv
hw/rtl/hrmp_rr_ram.sv
hw/rtl/heart_rate_measurement_packer.sv
verif/hrmp_packet_checker.sv
verif/heart_rate_measurement_packer_tb.sv
